// ===== rtl/vcd_pkg.sv =====
// ----------------------------------------------------------------------------
// vcd_pkg
// shared field widths, status and action codes for the corner deduplicator
// ----------------------------------------------------------------------------
package vcd_pkg;

  // fixed field widths of the request and response payloads
  localparam int REF_IN_W   = 21;
  localparam int REF_W      = 20;
  localparam int VIDX_OUT_W = 12;
  localparam int STATUS_W   = 2;

  // hash mixing constant
  localparam logic [31:0] GOLDEN = 32'h9e3779b9;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_FULL = 2'd1;
  localparam status_t STATUS_BAD  = 2'd2;

  typedef logic action_t;

  localparam action_t ACTION_LOOKUP = 1'b0;
  localparam action_t ACTION_CLEAR  = 1'b1;

endpackage

// ===== rtl/vcd_ifs.sv =====
// ----------------------------------------------------------------------------
// vcd request and response channels
// valid/ready channels carrying corner requests and vertex results
// ----------------------------------------------------------------------------
interface vcd_req_if import vcd_pkg::*; ();
  logic                valid;
  logic                ready;
  action_t             action;
  logic [REF_IN_W-1:0] position_ref_in;
  logic [REF_IN_W-1:0] texcoord_ref_in;
  logic [REF_IN_W-1:0] normal_ref_in;

  modport source (
    output valid, action, position_ref_in, texcoord_ref_in, normal_ref_in,
    input  ready
  );
  modport sink (
    input  valid, action, position_ref_in, texcoord_ref_in, normal_ref_in,
    output ready
  );
endinterface

interface vcd_rsp_if import vcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VIDX_OUT_W-1:0] vertex_index;
  logic                  is_new;
  logic [REF_W-1:0]      position_ref;
  logic [REF_W-1:0]      texcoord_ref;
  logic [REF_W-1:0]      normal_ref;
  status_t               status;

  modport source (
    output valid, vertex_index, is_new, position_ref, texcoord_ref, normal_ref, status,
    input  ready
  );
  modport sink (
    input  valid, vertex_index, is_new, position_ref, texcoord_ref, normal_ref, status,
    output ready
  );
endinterface

// ===== rtl/vcd_ram.sv =====
// ----------------------------------------------------------------------------
// vcd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vertex_corner_deduplicator_core.sv =====
// ----------------------------------------------------------------------------
// vertex_corner_deduplicator_core
// maps face-corner attribute triples to unique vertex indices through a
// linearly probed hash table held in one synchronous ram
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+--------------------------------------------
//  req     | in  | valid/ready  | action, position/texcoord/normal_ref_in
//  rsp     | out | valid/ready  | vertex_index, is_new, three refs, status
//
// a lookup steps through S_HASH1, S_HASH2 and S_PROBE, then S_CHECK for each table slot
// probed (one ram read per probe); its result is loaded into the output register in S_DONE.
// a bad index goes straight to S_DONE; a clear sweeps every slot (TABLE_SLOTS a power of two).
// after reset the ram is swept in S_CLEAR, with req.ready low.
// a new request is taken while the previous result still waits in the output
// register; the next result then holds in S_DONE until that one drains.
//
module vertex_corner_deduplicator_core import vcd_pkg::*; #(
  parameter int MAX_VERTICES = 4096,
  parameter int TABLE_SLOTS  = 8192,
  parameter int INDEX_BITS   = 20
) (
  input  logic       clk,
  input  logic       rst,
  vcd_req_if.sink    req,
  vcd_rsp_if.source  rsp
);

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int VAL_W   = $clog2(MAX_VERTICES);
  localparam int CNT_W   = VAL_W + 1;
  localparam int KEY_W   = 3 * INDEX_BITS;
  localparam int WORD_W  = 1 + KEY_W + VAL_W;
  // low slot bits of the 64-bit hash only depend on the low SLOT_W+4 bits
  localparam int HW      = SLOT_W + 4;
  localparam int PROBE_W = SLOT_W + 1;

  localparam logic [REF_IN_W:0] REF_LIMIT  = (REF_IN_W + 1)'(1) << INDEX_BITS;
  localparam logic [63:0]       GOLDEN_EXT = 64'(GOLDEN);
  localparam logic [HW-1:0]     GOLDEN_H   = GOLDEN_EXT[HW-1:0];
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [PROBE_W-1:0] PROBE_LAST = PROBE_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_VERTICES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_PROBE,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state;

  // clear sweep
  logic [SLOT_W-1:0] sweep_addr;
  logic              clear_reply;

  logic [CNT_W-1:0]    unique_count;

  // request being worked on
  logic [REF_IN_W-1:0] p_z, t_z, n_z;
  logic [KEY_W-1:0]    key;
  logic [HW-1:0]       h12;
  logic [SLOT_W-1:0]   slot;
  logic [PROBE_W-1:0]  probe_cnt;

  // pending result
  logic [VIDX_OUT_W-1:0] res_vidx;
  logic                  res_new;
  logic [REF_W-1:0]      res_p, res_t, res_n;
  status_t               res_status;

  // ram port
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // request decode
  logic [REF_IN_W-1:0] p_in, t_in, n_in;
  logic                bad_in;

  assign p_in = req.position_ref_in;
  assign t_in = req.texcoord_ref_in;
  assign n_in = req.normal_ref_in;

  assign bad_in = (p_in == '0) || (t_in == '0) || (n_in == '0) ||
                  ({1'b0, p_in} > REF_LIMIT) || ({1'b0, t_in} > REF_LIMIT) ||
                  ({1'b0, n_in} > REF_LIMIT);

  // hash mixing, done at HW bits
  logic [63:0]   p_ext, t_ext, n_ext;
  logic [HW-1:0] p_h, t_h, n_h, h12_next, h_full;

  assign p_ext = 64'(p_z);
  assign t_ext = 64'(t_z);
  assign n_ext = 64'(n_z);
  assign p_h   = p_ext[HW-1:0];
  assign t_h   = t_ext[HW-1:0];
  assign n_h   = n_ext[HW-1:0];

  assign h12_next = p_h ^ (t_h + GOLDEN_H + (p_h << 6) + (p_h >> 2));
  assign h_full   = h12 ^ (n_h + GOLDEN_H + (h12 << 6) + (h12 >> 2));

  // probe decode of the slot word read last cycle
  logic              rd_valid, rd_hit, rd_free, cnt_full, probe_last, do_insert;
  logic              probe_more;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;
  logic [SLOT_W-1:0] slot_inc;
  logic [31:0]       rd_val_ext, count_ext;

  assign rd_valid   = ram_rdata[WORD_W-1];
  assign rd_key     = ram_rdata[VAL_W +: KEY_W];
  assign rd_val     = ram_rdata[VAL_W-1:0];
  assign rd_free    = !rd_valid;
  assign rd_hit     = rd_valid && (rd_key == key);
  assign cnt_full   = unique_count >= CNT_MAX;
  assign probe_last = probe_cnt == PROBE_LAST;
  assign do_insert  = (state == S_CHECK) && rd_free && !cnt_full;
  assign probe_more = (state == S_CHECK) && rd_valid && !rd_hit && !probe_last;
  assign slot_inc   = slot + 1'b1;
  assign rd_val_ext = 32'(rd_val);
  assign count_ext  = 32'(unique_count);

  // ram control: sweep writes zero words, insert writes a valid entry
  always_comb begin
    ram_we    = (state == S_CLEAR) || do_insert;
    ram_waddr = (state == S_CLEAR) ? sweep_addr : slot;
    ram_wdata = (state == S_CLEAR) ? '0 :
                {1'b1, key, unique_count[VAL_W-1:0]};
    ram_re    = (state == S_PROBE) || probe_more;
    ram_raddr = (state == S_PROBE) ? slot : slot_inc;
  end

  vcd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      sweep_addr   <= '0;
      clear_reply  <= 1'b0;
      unique_count <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      // output register drains independently of the work in progress;
      // in S_DONE the reload below decides valid instead
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == SLOT_LAST) begin
            if (clear_reply) begin
              res_vidx   <= '0;
              res_new    <= 1'b0;
              res_p      <= '0;
              res_t      <= '0;
              res_n      <= '0;
              res_status <= STATUS_OK;
              state      <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            p_z <= p_in - 1'b1;
            t_z <= t_in - 1'b1;
            n_z <= n_in - 1'b1;
            key <= {n_in[INDEX_BITS-1:0] - 1'b1, t_in[INDEX_BITS-1:0] - 1'b1,
                    p_in[INDEX_BITS-1:0] - 1'b1};
            if (req.action == ACTION_CLEAR) begin
              clear_reply  <= 1'b1;
              unique_count <= '0;
              state        <= S_CLEAR;
            end else if (bad_in) begin
              res_vidx   <= '0;
              res_new    <= 1'b0;
              res_p      <= '0;
              res_t      <= '0;
              res_n      <= '0;
              res_status <= STATUS_BAD;
              state      <= S_DONE;
            end else begin
              state <= S_HASH1;
            end
          end
        end

        S_HASH1: begin
          h12   <= h12_next;
          state <= S_HASH2;
        end

        S_HASH2: begin
          slot      <= h_full[SLOT_W-1:0];
          probe_cnt <= '0;
          state     <= S_PROBE;
        end

        S_PROBE: begin
          state <= S_CHECK;
        end

        S_CHECK: begin
          res_p <= p_z[REF_W-1:0];
          res_t <= t_z[REF_W-1:0];
          res_n <= n_z[REF_W-1:0];
          if (rd_hit) begin
            res_vidx   <= rd_val_ext[VIDX_OUT_W-1:0];
            res_new    <= 1'b0;
            res_status <= STATUS_OK;
            state      <= S_DONE;
          end else if (do_insert) begin
            res_vidx     <= count_ext[VIDX_OUT_W-1:0];
            res_new      <= 1'b1;
            res_status   <= STATUS_OK;
            unique_count <= unique_count + 1'b1;
            state        <= S_DONE;
          end else if (rd_free || probe_last) begin
            // free slot with no vertex left, or every slot visited
            res_vidx   <= '0;
            res_new    <= 1'b0;
            res_status <= STATUS_FULL;
            state      <= S_DONE;
          end else begin
            slot      <= slot_inc;
            probe_cnt <= probe_cnt + 1'b1;
          end
        end

        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.vertex_index <= res_vidx;
            rsp.is_new       <= res_new;
            rsp.position_ref <= res_p;
            rsp.texcoord_ref <= res_t;
            rsp.normal_ref   <= res_n;
            rsp.status       <= res_status;
            clear_reply      <= 1'b0;
            state            <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/vcd_checker.sv =====
// ----------------------------------------------------------------------------
// vcd_checker
// port-level checks for the corner deduplicator, bound to the top level
// ----------------------------------------------------------------------------
module vcd_checker import vcd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [VIDX_OUT_W-1:0] rsp_vertex_index,
  input logic                  rsp_is_new,
  input logic [REF_W-1:0]      rsp_position_ref,
  input logic [REF_W-1:0]      rsp_texcoord_ref,
  input logic [REF_W-1:0]      rsp_normal_ref,
  input status_t               rsp_status
);

  // stalled result holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_vertex_index) &&
      $stable(rsp_status) && $stable(rsp_is_new)))
    else $error("stalled result changed");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  // a new vertex is always an ok result
  a_new_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_is_new) |-> (rsp_status == STATUS_OK))
    else $error("new vertex with error status");

  // bad index result is all zero
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == STATUS_BAD) |-> (rsp_vertex_index == '0 &&
      !rsp_is_new && rsp_position_ref == '0 && rsp_texcoord_ref == '0 &&
      rsp_normal_ref == '0))
    else $error("bad index result not cleared");

  // full result carries no vertex
  a_full_none: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == STATUS_FULL) |-> (rsp_vertex_index == '0 && !rsp_is_new))
    else $error("full result carries a vertex");

endmodule

bind vertex_corner_deduplicator_core vcd_checker u_vcd_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_vertex_index (rsp.vertex_index),
  .rsp_is_new       (rsp.is_new),
  .rsp_position_ref (rsp.position_ref),
  .rsp_texcoord_ref (rsp.texcoord_ref),
  .rsp_normal_ref   (rsp.normal_ref),
  .rsp_status       (rsp.status)
);
